/* design/two_region_sample_store_compactor_macros.svh */
// Assertion macros used by the checker file of the sample store.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef TWO_REGION_SAMPLE_STORE_COMPACTOR_MACROS_SVH
`define TWO_REGION_SAMPLE_STORE_COMPACTOR_MACROS_SVH

`define TRSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/trsc_pkg.sv */
// Shared types and codes of the two-region sample store.
// No dependencies; the interfaces, controller, datapath, top level and checker import it.
package trsc_pkg;

	localparam int MODE_W   = 3;
	localparam int DATA_W   = 32;
	localparam int LABEL_W  = 4;
	localparam int ADDR_W   = 10;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_APPEND     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INVALIDATE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAN      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MOVE       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MOVE_BIG = 2'd2;

	typedef enum logic [2:0] {
		PH_CLEAN_SHORT,
		PH_CLEAN_LONG,
		PH_MOVE_TAIL,
		PH_MOVE_XFER,
		PH_MOVE_SHIFT
	} phase_t;

	typedef struct packed {
		logic   clr;
		logic   load;
		logic   simple;
		logic   init;
		logic   rd;
		logic   ev;
		logic   cupd;
		logic   commit;
		logic   fin_rd;
		logic   load_out;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_clean;
		logic is_move;
		logic move_bad;
		logic walk_done;
		logic inv;
		logic counted;
		logic out_free;
	} st_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [DATA_W-1:0]  sample_data;
		logic [LABEL_W-1:0] sample_label;
		logic [ADDR_W-1:0]  entry_address;
		logic [CNT_W-1:0]   move_count;
		logic [LABEL_W-1:0] query_class;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    short_count;
		logic [CNT_W-1:0]    long_count;
		logic [CNT_W-1:0]    removed_short;
		logic [DATA_W-1:0]   read_data;
		logic [LABEL_W-1:0]  read_label;
		logic                read_invalid;
		logic [CNT_W-1:0]    class_long_count;
	} res_t;

endpackage

/* design/trsc_req_if.sv */
// Request channel of the sample store: valid/ready handshake and one command.
// Depends on trsc_pkg for field widths.
interface trsc_req_if import trsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [DATA_W-1:0]  sample_data;
	logic [LABEL_W-1:0] sample_label;
	logic [ADDR_W-1:0]  entry_address;
	logic [CNT_W-1:0]   move_count;
	logic [LABEL_W-1:0] query_class;

	modport source(output valid, mode, sample_data, sample_label, entry_address, move_count,
		query_class, input ready);
	modport sink(input valid, mode, sample_data, sample_label, entry_address, move_count,
		query_class, output ready);
endinterface

/* design/trsc_rsp_if.sv */
// Response channel of the sample store: valid/ready handshake and one result.
// Depends on trsc_pkg for field widths.
interface trsc_rsp_if import trsc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    short_count;
	logic [CNT_W-1:0]    long_count;
	logic [CNT_W-1:0]    removed_short;
	logic [DATA_W-1:0]   read_data;
	logic [LABEL_W-1:0]  read_label;
	logic                read_invalid;
	logic [CNT_W-1:0]    class_long_count;

	modport source(output valid, status, short_count, long_count, removed_short, read_data,
		read_label, read_invalid, class_long_count, input ready);
	modport sink(input valid, status, short_count, long_count, removed_short, read_data,
		read_label, read_invalid, class_long_count, output ready);
endinterface

/* design/trsc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module trsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* design/trsc_ctrl.sv */
// Controller of the sample store: sequences clearing, simple commands and entry walks.
// Depends on trsc_pkg for the command and status structs.
module trsc_ctrl import trsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  st_t  st,
	output cmd_t cmd
);
	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_OP   = 8'b0000_0100,
		S_RD   = 8'b0000_1000,
		S_EV   = 8'b0001_0000,
		S_CUPD = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	phase_t phase_q;

	always_comb begin
		cmd = '0;
		cmd.phase = phase_q;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_OP;
				end
			end
			S_OP: begin
				if (st.is_clean) begin
					cmd.init = 1'b1;
					cmd.phase = PH_CLEAN_SHORT;
					state_d = S_RD;
				end else if (st.is_move && !st.move_bad) begin
					cmd.init = 1'b1;
					cmd.phase = PH_MOVE_TAIL;
					state_d = S_RD;
				end else begin
					cmd.simple = 1'b1;
					cmd.fin_rd = 1'b1;
					state_d = S_DONE;
				end
			end
			S_RD: begin
				if (st.walk_done) begin
					case (phase_q)
						PH_CLEAN_SHORT: begin
							cmd.init = 1'b1;
							cmd.phase = PH_CLEAN_LONG;
						end
						PH_CLEAN_LONG: begin
							cmd.commit = 1'b1;
							state_d = S_FIN;
						end
						PH_MOVE_TAIL: begin
							cmd.init = 1'b1;
							cmd.phase = PH_MOVE_XFER;
						end
						PH_MOVE_XFER: begin
							cmd.init = 1'b1;
							cmd.phase = PH_MOVE_SHIFT;
						end
						default: begin
							cmd.commit = 1'b1;
							state_d = S_FIN;
						end
					endcase
				end else begin
					cmd.rd = 1'b1;
					state_d = S_EV;
				end
			end
			S_EV: begin
				cmd.ev = 1'b1;
				if ((phase_q == PH_CLEAN_LONG && st.inv && st.counted) ||
					(phase_q == PH_MOVE_XFER && st.counted)) begin
					state_d = S_CUPD;
				end else begin
					state_d = S_RD;
				end
			end
			S_CUPD: begin
				cmd.cupd = 1'b1;
				state_d = S_RD;
			end
			S_FIN: begin
				cmd.fin_rd = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			phase_q <= PH_CLEAN_SHORT;
		end else begin
			state_q <= state_d;
			if (cmd.init) begin
				phase_q <= cmd.phase;
			end
		end
	end
endmodule

/* design/trsc_dpath.sv */
// Datapath of the sample store: fill counters, walk pointers, the two sample banks,
// the invalid flags, the per-class counters and the result register. Depends on trsc_pkg and trsc_ram.
module trsc_dpath import trsc_pkg::*; #(
	parameter int STORE_DEPTH = 1024,
	parameter int CLASS_COUNT = 16,
	parameter int SAMPLE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output st_t  st,
	input  req_t req,
	output logic out_valid,
	input  logic out_ready,
	output res_t res
);
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int FW   = $clog2(STORE_DEPTH + 1);
	localparam int CAW  = $clog2(CLASS_COUNT);
	localparam int CLRN = (STORE_DEPTH > CLASS_COUNT) ? STORE_DEPTH : CLASS_COUNT;
	localparam int CLW  = $clog2(CLRN);
	localparam int XW   = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
	localparam int NW   = ((FW > CNT_W) ? FW : CNT_W) + 1;
	localparam int LCW  = ((CAW > LABEL_W) ? CAW : LABEL_W) + 1;
	localparam int EW   = SAMPLE_BITS + LABEL_W;

	logic [MODE_W-1:0]      mode_q;
	logic [SAMPLE_BITS-1:0] data_q;
	logic [LABEL_W-1:0]     label_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [CNT_W-1:0]       n_q;
	logic [LABEL_W-1:0]     query_q;
	logic [FW-1:0]          short_q, long_q, left_q, kept_q, removed_q;
	logic                   bank_q;
	logic [AW-1:0]          src_q, dst_q;
	logic [LABEL_W-1:0]     lab_q;
	logic [CLW-1:0]         clr_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   out_valid_q;
	res_t                   res_q;

	logic                   addr_ok, query_ok, full, move_bad, counted, is_clean_ph;
	logic [FW-1:0]          n_f, tail_len;
	logic [AW-1:0]          first_a, base_a;
	logic [EW-1:0]          ent0, ent1, ent;
	logic [SAMPLE_BITS-1:0] ent_data;
	logic [LABEL_W-1:0]     ent_label;
	logic                   inv_rdata;
	logic [FW-1:0]          cnt_rdata;

	logic                   bw_en, bw_to_wr, tgt;
	logic [AW-1:0]          bw_addr, b_raddr;
	logic [EW-1:0]          bw_data;
	logic                   b_re;

	logic                   iw_en, iw_data;
	logic [AW-1:0]          iw_addr;

	logic                   cw_en, c_re;
	logic [CAW-1:0]         cw_addr, c_raddr;
	logic [FW-1:0]          cw_data;

	assign addr_ok  = XW'(addr_q) < XW'(STORE_DEPTH);
	assign query_ok = LCW'(query_q) < LCW'(CLASS_COUNT);
	assign full     = ({1'b0, short_q} + {1'b0, long_q}) >= (FW + 1)'(STORE_DEPTH);
	assign move_bad = NW'(n_q) > NW'(short_q);
	assign n_f      = FW'(n_q);
	assign first_a  = (long_q < FW'(STORE_DEPTH)) ?
		(AW'(STORE_DEPTH - 1) - AW'(long_q)) : '0;
	assign tail_len = (long_q < FW'(STORE_DEPTH)) ? (long_q + 1'b1) : FW'(STORE_DEPTH);
	assign base_a   = AW'(FW'(STORE_DEPTH) - long_q - n_f);

	assign ent       = bank_q ? ent1 : ent0;
	assign ent_data  = ent[SAMPLE_BITS-1:0];
	assign ent_label = ent[EW-1 -: LABEL_W];
	assign counted   = LCW'(ent_label) < LCW'(CLASS_COUNT);
	assign is_clean_ph = (cmd.phase == PH_CLEAN_SHORT) || (cmd.phase == PH_CLEAN_LONG);

	always_comb begin
		bw_en = 1'b0;
		bw_to_wr = 1'b0;
		bw_addr = AW'(short_q);
		bw_data = {label_q, data_q};
		if (cmd.simple && mode_q == MODE_APPEND && !full) begin
			bw_en = 1'b1;
		end else if (cmd.ev) begin
			bw_to_wr = 1'b1;
			bw_data = ent;
			case (cmd.phase)
				PH_CLEAN_SHORT: begin
					bw_en = !inv_rdata;
					bw_addr = AW'(kept_q);
				end
				PH_CLEAN_LONG: begin
					bw_en = !inv_rdata;
					bw_addr = AW'(STORE_DEPTH - 1) - AW'(kept_q);
				end
				default: begin
					bw_en = 1'b1;
					bw_addr = dst_q;
				end
			endcase
		end
	end

	assign tgt     = bank_q ^ bw_to_wr;
	assign b_re    = cmd.simple | cmd.rd;
	assign b_raddr = cmd.simple ? AW'(addr_q) : src_q;

	always_comb begin
		iw_en = 1'b0;
		iw_addr = src_q;
		iw_data = 1'b0;
		if (cmd.clr) begin
			iw_en = (CLW + 1)'(clr_q) < (CLW + 1)'(STORE_DEPTH);
			iw_addr = AW'(clr_q);
		end else if (cmd.simple && mode_q == MODE_INVALIDATE && addr_ok) begin
			iw_en = 1'b1;
			iw_addr = AW'(addr_q);
			iw_data = 1'b1;
		end else if (cmd.ev && is_clean_ph && inv_rdata) begin
			iw_en = 1'b1;
		end
	end

	always_comb begin
		cw_en = cmd.cupd;
		cw_addr = CAW'(lab_q);
		if (cmd.phase == PH_CLEAN_LONG) begin
			cw_data = (cnt_rdata != '0) ? (cnt_rdata - 1'b1) : cnt_rdata;
		end else begin
			cw_data = cnt_rdata + 1'b1;
		end
		if (cmd.clr) begin
			cw_en = (CLW + 1)'(clr_q) < (CLW + 1)'(CLASS_COUNT);
			cw_addr = CAW'(clr_q);
			cw_data = '0;
		end
	end

	assign c_re    = cmd.fin_rd | cmd.ev;
	assign c_raddr = cmd.fin_rd ? CAW'(query_q) : CAW'(ent_label);

	trsc_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH)) u_bank0 (
		.clk(clk), .we(bw_en && !tgt), .waddr(bw_addr), .wdata(bw_data),
		.re(b_re), .raddr(b_raddr), .rdata(ent0)
	);

	trsc_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH)) u_bank1 (
		.clk(clk), .we(bw_en && tgt), .waddr(bw_addr), .wdata(bw_data),
		.re(b_re), .raddr(b_raddr), .rdata(ent1)
	);

	trsc_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_inv (
		.clk(clk), .we(iw_en), .waddr(iw_addr), .wdata(iw_data),
		.re(b_re), .raddr(b_raddr), .rdata(inv_rdata)
	);

	trsc_ram #(.WIDTH(FW), .DEPTH(CLASS_COUNT)) u_cnt (
		.clk(clk), .we(cw_en), .waddr(cw_addr), .wdata(cw_data),
		.re(c_re), .raddr(c_raddr), .rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= '0;
			long_q <= '0;
			bank_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.simple && mode_q == MODE_APPEND && !full) begin
				short_q <= short_q + 1'b1;
			end
			if (cmd.init && cmd.phase == PH_CLEAN_LONG) begin
				short_q <= kept_q;
			end
			if (cmd.commit) begin
				bank_q <= ~bank_q;
				if (cmd.phase == PH_CLEAN_LONG) begin
					long_q <= kept_q;
				end else begin
					short_q <= short_q - n_f;
					long_q <= long_q + n_f;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			data_q <= SAMPLE_BITS'(req.sample_data);
			label_q <= req.sample_label;
			addr_q <= req.entry_address;
			n_q <= req.move_count;
			query_q <= req.query_class;
			status_q <= STAT_OK;
			removed_q <= '0;
		end
		if (cmd.simple) begin
			if (mode_q == MODE_APPEND && full) begin
				status_q <= STAT_FULL;
			end else if (mode_q == MODE_MOVE && move_bad) begin
				status_q <= STAT_MOVE_BIG;
			end
		end
		if (cmd.init) begin
			case (cmd.phase)
				PH_CLEAN_SHORT: begin
					src_q <= '0;
					left_q <= short_q;
					kept_q <= '0;
				end
				PH_CLEAN_LONG: begin
					removed_q <= short_q - kept_q;
					src_q <= AW'(STORE_DEPTH - 1);
					left_q <= long_q;
					kept_q <= '0;
				end
				PH_MOVE_TAIL: begin
					src_q <= first_a;
					dst_q <= first_a;
					left_q <= tail_len;
				end
				PH_MOVE_XFER: begin
					src_q <= '0;
					dst_q <= base_a;
					left_q <= n_f;
				end
				default: begin
					src_q <= AW'(n_f);
					dst_q <= '0;
					left_q <= short_q - n_f;
				end
			endcase
		end
		if (cmd.ev) begin
			left_q <= left_q - 1'b1;
			lab_q <= ent_label;
			case (cmd.phase)
				PH_CLEAN_SHORT: begin
					src_q <= src_q + 1'b1;
					if (!inv_rdata) begin
						kept_q <= kept_q + 1'b1;
					end
				end
				PH_CLEAN_LONG: begin
					src_q <= src_q - 1'b1;
					if (!inv_rdata) begin
						kept_q <= kept_q + 1'b1;
					end
				end
				default: begin
					src_q <= src_q + 1'b1;
					dst_q <= dst_q + 1'b1;
				end
			endcase
		end
		if (cmd.load_out) begin
			res_q.status <= status_q;
			res_q.short_count <= CNT_W'(short_q);
			res_q.long_count <= CNT_W'(long_q);
			res_q.removed_short <= CNT_W'(removed_q);
			res_q.class_long_count <= query_ok ? CNT_W'(cnt_rdata) : '0;
			if (mode_q == MODE_READ && addr_ok) begin
				res_q.read_data <= DATA_W'(ent_data);
				res_q.read_label <= ent_label;
				res_q.read_invalid <= inv_rdata;
			end else begin
				res_q.read_data <= '0;
				res_q.read_label <= '0;
				res_q.read_invalid <= 1'b0;
			end
		end
	end

	assign st.clr_last  = clr_q == CLW'(CLRN - 1);
	assign st.is_clean  = mode_q == MODE_CLEAN;
	assign st.is_move   = mode_q == MODE_MOVE;
	assign st.move_bad  = move_bad;
	assign st.walk_done = left_q == '0;
	assign st.inv       = inv_rdata;
	assign st.counted   = counted;
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign res = res_q;
endmodule

/* design/two_region_sample_store_compactor.sv */
// Top level of the two-region sample store; joins controller and datapath to the channels.
// Depends on trsc_pkg, trsc_req_if, trsc_rsp_if, trsc_ctrl and trsc_dpath.
// The block takes one command at a time and answers each with exactly one result.
// After reset it clears the invalid flags and class counters before the request
// channel is ready. Append, invalidate, read and rejected commands need no entry
// walk. A clean and a move walk over the entries of the store: the entry walk reads
// one entry from the active bank and writes it to the other bank unless a clean drops
// it as invalid, with a read-modify-write of the class counter memory where a counter
// changes. The result sits in an output register, so the next command is taken while
// an earlier result waits for its transfer.
module two_region_sample_store_compactor import trsc_pkg::*; #(
	parameter int STORE_DEPTH = 1024,
	parameter int CLASS_COUNT = 16,
	parameter int SAMPLE_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	trsc_req_if.sink   req,
	trsc_rsp_if.source rsp
);
	cmd_t cmd;
	st_t  st;
	req_t req_pl;
	res_t res;
	logic in_ready;

	assign req_pl = '{
		mode:          req.mode,
		sample_data:   req.sample_data,
		sample_label:  req.sample_label,
		entry_address: req.entry_address,
		move_count:    req.move_count,
		query_class:   req.query_class
	};

	assign req.ready = in_ready;

	trsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(in_ready),
		.st(st), .cmd(cmd)
	);

	trsc_dpath #(
		.STORE_DEPTH(STORE_DEPTH), .CLASS_COUNT(CLASS_COUNT), .SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .req(req_pl),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .res(res)
	);

	assign rsp.status           = res.status;
	assign rsp.short_count      = res.short_count;
	assign rsp.long_count       = res.long_count;
	assign rsp.removed_short    = res.removed_short;
	assign rsp.read_data        = res.read_data;
	assign rsp.read_label       = res.read_label;
	assign rsp.read_invalid     = res.read_invalid;
	assign rsp.class_long_count = res.class_long_count;
endmodule

/* design/trsc_checker.sv */
// Port-level checks of the sample store, bound to the top level.
// Depends on trsc_pkg and the macro header.
`include "two_region_sample_store_compactor_macros.svh"

module trsc_checker import trsc_pkg::*; #(
	parameter int STORE_DEPTH = 1024
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [CNT_W-1:0]    short_count,
	input logic [CNT_W-1:0]    long_count,
	input logic [CNT_W-1:0]    removed_short
);
	logic [CNT_W:0] total;

	assign total = {1'b0, short_count} + {1'b0, long_count};

	`TRSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "result dropped before transfer")
	`TRSC_ASSERT_NOW(a_fill_bound, rsp_valid, 32'(total) <= 32'(STORE_DEPTH), "regions exceed store depth")
	`TRSC_ASSERT_NOW(a_full_total, rsp_valid && status == STAT_FULL, 32'(total) == 32'(STORE_DEPTH), "full status with free space")
	`TRSC_ASSERT_NOW(a_err_no_removal, rsp_valid && status != STAT_OK, removed_short == '0, "rejected command removed entries")
endmodule

bind two_region_sample_store_compactor trsc_checker #(.STORE_DEPTH(STORE_DEPTH)) u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.short_count(rsp.short_count),
	.long_count(rsp.long_count),
	.removed_short(rsp.removed_short)
);
